// File: src/svhist_pkg.sv
// Shared types and constants for the sparse value histogram.
// Holds the field widths, the mode codes and the sequencer state encoding.
// No dependencies.
package svhist_pkg;

    localparam int SAMPLE_W = 32;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 32;
    localparam int USED_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_SORT   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_REC      = 7'b0000010,
        S_SORT_LD  = 7'b0000100,
        S_SORT_CUR = 7'b0001000,
        S_SORT     = 7'b0010000,
        S_READ     = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

endpackage

// File: src/sparse_value_histogram.sv
// Sparse value histogram: value/count bins kept in a single-port-write memory,
// scanned by an equality and sorted by a magnitude compare under a small sequencer.
// Depends on svhist_pkg.
//
// Usage: the input channel (i_valid, o_stall) takes one transaction holding a
// mode, a sample value and a bin index. The block raises o_stall from the cycle
// after acceptance until the transaction is finished, so one item is in work
// at a time. Each transaction gives exactly one result on the output channel
// (o_valid, i_stall); the result sits in an output register, so the block
// returns to idle and takes the next transaction while that result waits.
// Record scans the occupied bins from bin 0, one memory read per cycle, and
// stops at the first match, whose count it raises, saturating at its maximum;
// with no match it claims the next free bin, or drops the sample when the
// table is full. Sort is an exchange sort into ascending value order, one
// compare per cycle in the inner pass. Read fetches the indexed bin. The
// unused mode and a sort of one bin or none go straight to the final step.
// The result appears in the cycle after the last busy cycle, when o_stall also
// drops, if the output register is free; while the receiver stalls, the result
// is held and the block waits in its final step before loading the next one.
// Reset empties the table at once by clearing the occupied count; bins past
// that count are never used, so no clearing pass over the memory is needed.
module sparse_value_histogram
    import svhist_pkg::*;
#(
    parameter int BINS        = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_mode,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    input  logic [INDEX_W-1:0]  i_bin_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_bin_value,
    output logic [COUNT_W-1:0]  o_bin_count,
    output logic [USED_W-1:0]   o_used_bins,
    output logic                o_table_full,
    output logic                o_sample_dropped
);

    localparam int IW = $clog2(BINS);
    localparam int CW = $clog2(BINS + 1);
    localparam int KW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [VALUE_WIDTH-1:0] mem_val [BINS];
    logic [COUNT_W-1:0]     mem_cnt [BINS];

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_sample, n_sample;
    logic [CW-1:0]          r_occ, n_occ;
    logic [CW-1:0]          r_ptr, n_ptr;
    logic [IW-1:0]          r_a, n_a;
    logic [VALUE_WIDTH-1:0] r_cur_val, n_cur_val;
    logic [COUNT_W-1:0]     r_cur_cnt, n_cur_cnt;
    logic                   r_rd_vld, n_rd_vld;
    logic [IW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_rd_ok, n_rd_ok;
    logic [VALUE_WIDTH-1:0] r_rd_val;
    logic [COUNT_W-1:0]     r_rd_cnt;
    logic [SAMPLE_W-1:0]    r_res_val, n_res_val;
    logic [COUNT_W-1:0]     r_res_cnt, n_res_cnt;
    logic                   r_res_drop, n_res_drop;
    logic                   r_out_vld, n_out_vld;
    logic [SAMPLE_W-1:0]    r_out_val, n_out_val;
    logic [COUNT_W-1:0]     r_out_cnt, n_out_cnt;
    logic [USED_W-1:0]      r_out_used, n_out_used;
    logic                   r_out_full, n_out_full;
    logic                   r_out_drop, n_out_drop;

    logic [IW-1:0]          rd_addr;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_val;
    logic [COUNT_W-1:0]     wr_cnt;
    logic [KW-1:0]          idx_k;
    logic [KW-1:0]          occ_k;
    logic                   issue;
    logic                   out_free;

    assign idx_k    = KW'(i_bin_index);
    assign occ_k    = KW'(r_occ);
    assign issue    = (r_ptr < r_occ);
    assign out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_state    = r_state;
        n_sample   = r_sample;
        n_occ      = r_occ;
        n_ptr      = r_ptr;
        n_a        = r_a;
        n_cur_val  = r_cur_val;
        n_cur_cnt  = r_cur_cnt;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_rd_ok    = r_rd_ok;
        n_res_val  = r_res_val;
        n_res_cnt  = r_res_cnt;
        n_res_drop = r_res_drop;
        n_out_vld  = r_out_vld && i_stall;
        n_out_val  = r_out_val;
        n_out_cnt  = r_out_cnt;
        n_out_used = r_out_used;
        n_out_full = r_out_full;
        n_out_drop = r_out_drop;
        rd_addr    = r_ptr[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_rd_idx;
        wr_val     = r_cur_val;
        wr_cnt     = r_cur_cnt;

        case (r_state)
            S_IDLE: begin
                rd_addr = idx_k[IW-1:0];
                if (i_valid) begin
                    n_sample   = VALUE_WIDTH'(i_sample_value);
                    n_ptr      = '0;
                    n_a        = '0;
                    n_res_val  = '0;
                    n_res_cnt  = '0;
                    n_res_drop = 1'b0;
                    case (i_mode)
                        MODE_RECORD: n_state = S_REC;
                        MODE_SORT:   n_state = (r_occ > CW'(1)) ? S_SORT_LD : S_FIN;
                        MODE_READ: begin
                            // Bins at or past the occupied count read as zero.
                            n_rd_ok = (idx_k < occ_k);
                            n_state = S_READ;
                        end
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_REC: begin
                if (issue) begin
                    n_ptr    = r_ptr + CW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[IW-1:0];
                end
                if (r_rd_vld && (r_rd_val == r_sample)) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_rd_idx;
                    wr_val   = r_rd_val;
                    wr_cnt   = (r_rd_cnt == COUNT_MAX) ? r_rd_cnt : r_rd_cnt + COUNT_W'(1);
                    n_rd_vld = 1'b0;
                    n_state  = S_FIN;
                end else if (!r_rd_vld && !issue) begin
                    // The scan found no match: claim the next free bin if any.
                    if (r_occ == CW'(BINS)) begin
                        n_res_drop = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_occ[IW-1:0];
                        wr_val  = r_sample;
                        wr_cnt  = COUNT_W'(1);
                        n_occ   = r_occ + CW'(1);
                    end
                    n_state = S_FIN;
                end
            end
            S_SORT_LD: begin
                rd_addr = r_a;
                n_state = S_SORT_CUR;
            end
            S_SORT_CUR: begin
                n_cur_val = r_rd_val;
                n_cur_cnt = r_rd_cnt;
                n_ptr     = CW'(r_a) + CW'(1);
                n_state   = S_SORT;
            end
            S_SORT: begin
                if (issue) begin
                    n_ptr    = r_ptr + CW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[IW-1:0];
                end
                // The bin being placed lives in r_cur; a smaller bin found
                // later swaps with it, and it is written back when the pass ends.
                if (r_rd_vld) begin
                    if (r_cur_val > r_rd_val) begin
                        wr_en     = 1'b1;
                        wr_addr   = r_rd_idx;
                        n_cur_val = r_rd_val;
                        n_cur_cnt = r_rd_cnt;
                    end
                end else if (!issue) begin
                    wr_en   = 1'b1;
                    wr_addr = r_a;
                    n_a     = r_a + IW'(1);
                    n_state = ((CW + 1)'(r_a) + (CW + 1)'(2) < (CW + 1)'(r_occ)) ?
                              S_SORT_LD : S_FIN;
                end
            end
            S_READ: begin
                n_res_val = r_rd_ok ? SAMPLE_W'(r_rd_val) : '0;
                n_res_cnt = r_rd_ok ? r_rd_cnt : '0;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_val  = r_res_val;
                    n_out_cnt  = r_res_cnt;
                    n_out_used = USED_W'(r_occ);
                    n_out_full = (r_occ == CW'(BINS));
                    n_out_drop = r_res_drop;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_val[wr_addr] <= wr_val;
            mem_cnt[wr_addr] <= wr_cnt;
        end
        r_rd_val <= mem_val[rd_addr];
        r_rd_cnt <= mem_cnt[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_ptr      <= n_ptr;
        r_a        <= n_a;
        r_cur_val  <= n_cur_val;
        r_cur_cnt  <= n_cur_cnt;
        r_rd_idx   <= n_rd_idx;
        r_rd_ok    <= n_rd_ok;
        r_res_val  <= n_res_val;
        r_res_cnt  <= n_res_cnt;
        r_res_drop <= n_res_drop;
        r_out_val  <= n_out_val;
        r_out_cnt  <= n_out_cnt;
        r_out_used <= n_out_used;
        r_out_full <= n_out_full;
        r_out_drop <= n_out_drop;
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_vld;
    assign o_bin_value      = r_out_val;
    assign o_bin_count      = r_out_cnt;
    assign o_used_bins      = r_out_used;
    assign o_table_full     = r_out_full;
    assign o_sample_dropped = r_out_drop;

endmodule

// File: src/svhist_chk.sv
// Port-level checker for the sparse value histogram, attached by bind.
// Depends on svhist_pkg for the field widths and on the top level's ports.
module svhist_chk
    import svhist_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic [1:0]          i_mode,
    input logic [SAMPLE_W-1:0] i_sample_value,
    input logic [INDEX_W-1:0]  i_bin_index,
    input logic                o_valid,
    input logic                i_stall,
    input logic [SAMPLE_W-1:0] o_bin_value,
    input logic [COUNT_W-1:0]  o_bin_count,
    input logic [USED_W-1:0]   o_used_bins,
    input logic                o_table_full,
    input logic                o_sample_dropped
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bin_value) && $stable(o_bin_count)
        && $stable(o_used_bins) && $stable(o_table_full) && $stable(o_sample_dropped))
        else $error("stalled result changed");

    // Only one item is in work: the block stalls right after taking one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while previous item in work");

    // A sample is dropped only when no free bin is left.
    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sample_dropped |-> o_table_full)
        else $error("sample dropped while table not full");

    // An empty or absent bin reads as value zero.
    a_empty_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_bin_count == '0) |-> (o_bin_value == '0))
        else $error("empty bin carries a value");

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind sparse_value_histogram svhist_chk u_svhist_chk (.*);
